/* rtl/core/scope_trace_span_renderer_unit_assert.svh */
// Assertion macros shared by the span renderer RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SCOPE_TRACE_SPAN_RENDERER_UNIT_ASSERT_SVH
`define SCOPE_TRACE_SPAN_RENDERER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge out of reset
`define STSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle
`define STSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/stsr_pkg.sv */
// Shared types and constants for the scope trace span renderer.
// No dependencies; used by every module of the block.
`default_nettype none

package stsr_pkg;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned ScaleDiv  = 65533;
  localparam int unsigned CountMax  = 4095;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    RegViewHeight = 2'd0,
    RegViewWidth  = 2'd1,
    RegBeamColor  = 2'd2,
    RegNullColor  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0] view_height;
    logic [12:0] view_width;
    logic [7:0]  beam_color;
    logic [7:0]  null_color;
  } cfg_t;

  // One bent pair that survived the column check, waiting for the back end
  typedef struct packed {
    logic [11:0]        column;
    logic signed [15:0] top;
    logic signed [15:0] bot;
    logic [7:0]         color;
  } item_t;

  // Clip a 13-bit size register to the largest supported dimension
  function automatic logic [12:0] clip_dim(logic [12:0] v);
    logic [12:0] lim;
    lim = 13'(MaxDim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scope_trace_span_renderer_unit.sv */
// Top level of the scope trace span renderer: configuration registers,
// front end, span queue and back end. Depends on stsr_pkg and all submodules.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: sample_top, sample_bottom
//                                                tuser: first_pair, live_frame
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: column, row_top, row_bottom,
//                                                       pixel_color
//  cfg       in   cfg_we_i                       cfg_addr_i, cfg_wdata_i
//
// One pair is accepted per cycle while the queue is not full; a span passes a
// queue entry and the two back-end stages (multiply, then divide-by-constant
// and clamp) before it leaves. Reset is asynchronous, active low, and needs
// no clearing pass. s_axis_tready drops only when the four-entry queue is full,
// so a stalled m_axis absorbs six spans (output register, stage 1 and the four
// queue entries) before it pushes back; dropped pairs also wait while the queue is full.
`default_nettype none

module scope_trace_span_renderer_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,   // [15:0] sample_top, [31:16] sample_bottom
  input  wire logic [1:0]    s_axis_tuser,   // [0] first_pair, [1] live_frame
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // [11:0] column, [23:12] row_top,
                                             // [35:24] row_bottom, [43:36] pixel_color
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_addr_i,
  input  wire logic [12:0]   cfg_wdata_i
);

  stsr_pkg::cfg_t  cfg_q;
  stsr_pkg::item_t push_data, pop_data;
  logic            push, full, q_valid, q_pop;
  logic [11:0]     column, row_top, row_bottom;
  logic [7:0]      pixel_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_height <= 13'd256;
      cfg_q.view_width  <= 13'd320;
      cfg_q.beam_color  <= 8'd0;
      cfg_q.null_color  <= 8'd0;
    end else if (cfg_we_i) begin
      case (stsr_pkg::cfg_idx_e'(cfg_addr_i))
        stsr_pkg::RegViewHeight: cfg_q.view_height <= cfg_wdata_i;
        stsr_pkg::RegViewWidth:  cfg_q.view_width  <= cfg_wdata_i;
        stsr_pkg::RegBeamColor:  cfg_q.beam_color  <= cfg_wdata_i[7:0];
        stsr_pkg::RegNullColor:  cfg_q.null_color  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  stsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .sample_top_i    (s_axis_tdata[15:0]),
    .sample_bottom_i (s_axis_tdata[31:16]),
    .first_pair_i    (s_axis_tuser[0]),
    .live_frame_i    (s_axis_tuser[1]),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  stsr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data)
  );

  stsr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_data_i      (pop_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .column_o      (column),
    .row_top_o     (row_top),
    .row_bottom_o  (row_bottom),
    .pixel_color_o (pixel_color)
  );

  assign m_axis_tdata = {4'b0000, pixel_color, row_bottom, row_top, column};

endmodule

`default_nettype wire

/* rtl/core/stsr_fifo.sv */
// Short queue between the front and back end of the span renderer.
// Depends on stsr_pkg for the item type and depth.
`default_nettype none

`include "scope_trace_span_renderer_unit_assert.svh"

module stsr_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  stsr_pkg::item_t     push_data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output stsr_pkg::item_t     pop_data_o
);

  stsr_pkg::item_t                   mem_q [stsr_pkg::FifoDepth];
  logic [stsr_pkg::FifoPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [stsr_pkg::FifoCntW-1:0]     cnt_q;
  logic                              do_push, do_pop;

  assign full_o     = (cnt_q == stsr_pkg::FifoCntW'(stsr_pkg::FifoDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `STSR_ASSERT(a_fifo_no_overflow, cnt_q <= stsr_pkg::FifoCntW'(stsr_pkg::FifoDepth), "fifo count past depth")
  `STSR_ASSERT_IMP(a_fifo_push_room, push_i, !full_o, "push into a full fifo")
  `STSR_ASSERT(a_fifo_ptr_gap, wr_ptr_q == stsr_pkg::FifoPtrW'(rd_ptr_q + cnt_q), "fifo pointers out of step")

endmodule

`default_nettype wire

/* rtl/core/stsr_front.sv */
// Front end: takes sample pairs, bends them toward the previous pair,
// counts columns and drops columns past the view. Depends on stsr_pkg.
`default_nettype none

module stsr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  stsr_pkg::cfg_t      cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [15:0]    sample_top_i,
  input  wire logic [15:0]    sample_bottom_i,
  input  wire logic           first_pair_i,
  input  wire logic           live_frame_i,
  output logic                push_o,
  output stsr_pkg::item_t     push_data_o,
  input  wire logic           full_i
);

  logic signed [15:0] prev_top_q, prev_top_d;
  logic signed [15:0] prev_bot_q, prev_bot_d;
  logic [11:0]        col_q, col_d;
  logic signed [15:0] top_in, bot_in, bot_b, top_b;
  logic [12:0]        width;
  logic               col_fits, accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign top_in     = $signed(sample_top_i);
  assign bot_in     = $signed(sample_bottom_i);
  assign width      = stsr_pkg::clip_dim(cfg_i.view_width);
  // column <= width-2, written without going negative
  assign col_fits   = ({2'b00, col_q} + 14'd2) <= {1'b0, width};

  always_comb begin
    // bend the new pair so its span touches the previous one
    bot_b = bot_in;
    if (top_in > prev_top_q && bot_in > prev_top_q) bot_b = prev_top_q;
    top_b = top_in;
    if (top_in < prev_bot_q && bot_b < prev_bot_q) top_b = prev_bot_q;

    prev_top_d = prev_top_q;
    prev_bot_d = prev_bot_q;
    col_d      = col_q;
    if (accept) begin
      if (first_pair_i) begin
        prev_top_d = top_in;
        prev_bot_d = bot_in;
        col_d      = '0;
      end else begin
        prev_top_d = top_b;
        prev_bot_d = bot_b;
        if (col_q != 12'(stsr_pkg::CountMax)) col_d = col_q + 1'b1;
      end
    end
  end

  assign push_o             = accept && !first_pair_i && col_fits;
  assign push_data_o.column = col_q;
  assign push_data_o.top    = top_b;
  assign push_data_o.bot    = bot_b;
  assign push_data_o.color  = live_frame_i ? cfg_i.beam_color : cfg_i.null_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_top_q <= '0;
      prev_bot_q <= '0;
      col_q      <= '0;
    end else begin
      prev_top_q <= prev_top_d;
      prev_bot_q <= prev_bot_d;
      col_q      <= col_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/stsr_back.sv */
// Back end: scales both ends of a span to rows, clamps them into the view
// and holds the result in an output register. Depends on stsr_pkg.
`default_nettype none

`include "scope_trace_span_renderer_unit_assert.svh"

module stsr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  stsr_pkg::cfg_t      cfg_i,
  input  wire logic           q_valid_i,
  output logic                q_pop_o,
  input  stsr_pkg::item_t     q_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [11:0]         column_o,
  output logic [11:0]         row_top_o,
  output logic [11:0]         row_bottom_o,
  output logic [7:0]          pixel_color_o
);

  // Stage 1: products v*H
  logic               s1_valid_q;
  logic [11:0]        s1_col_q;
  logic [7:0]         s1_color_q;
  logic signed [28:0] s1_ptop_q, s1_pbot_q;
  // Output register
  logic               out_valid_q;
  logic [11:0]        out_col_q, out_rtop_q, out_rbot_q;
  logic [7:0]         out_color_q;

  logic [12:0]        height;
  logic signed [29:0] mul_top, mul_bot;
  logic signed [14:0] row_t, row_b;
  logic               oob_t, oob_b, emit, out_free, s1_adv;
  logic [11:0]        clamp_t, clamp_b, h_last;

  // H/2 - trunc(p / 65533); |p| < 2^28 so one correction step suffices
  function automatic logic signed [14:0] to_row(logic signed [28:0] p, logic [11:0] hh);
    logic [27:0]        ap;
    logic [11:0]        q0, q;
    logic [16:0]        rem;
    logic signed [14:0] qs;
    ap  = p[28] ? 28'(-p) : p[27:0];
    q0  = ap[27:16];
    rem = {1'b0, ap[15:0]} + 17'(q0) * 17'd3;
    q   = (rem >= 17'(stsr_pkg::ScaleDiv)) ? q0 + 1'b1 : q0;
    qs  = p[28] ? -$signed({3'b000, q}) : $signed({3'b000, q});
    return $signed({3'b000, hh}) - qs;
  endfunction

  assign height  = stsr_pkg::clip_dim(cfg_i.view_height);
  assign mul_top = q_data_i.top * $signed({1'b0, height});
  assign mul_bot = q_data_i.bot * $signed({1'b0, height});

  assign row_t   = to_row(s1_ptop_q, height[12:1]);
  assign row_b   = to_row(s1_pbot_q, height[12:1]);
  assign oob_t   = row_t[14] || (row_t >= $signed({2'b00, height}));
  assign oob_b   = row_b[14] || (row_b >= $signed({2'b00, height}));
  assign h_last  = 12'(height - 13'd1);
  assign clamp_t = oob_t ? (row_t[14] ? 12'd0 : h_last) : row_t[11:0];
  assign clamp_b = oob_b ? (row_b[14] ? 12'd0 : h_last) : row_b[11:0];
  assign emit    = !(oob_t && oob_b) && !(clamp_b < clamp_t);

  assign out_free = !out_valid_q || out_ready_i;
  // a dropped span leaves stage 1 without needing the output register
  assign s1_adv   = !s1_valid_q || !emit || out_free;
  assign q_pop_o  = q_valid_i && s1_adv;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_col_q   <= q_data_i.column;
      s1_color_q <= q_data_i.color;
      s1_ptop_q  <= mul_top[28:0];
      s1_pbot_q  <= mul_bot[28:0];
    end
    if (s1_valid_q && emit && out_free) begin
      out_col_q   <= s1_col_q;
      out_rtop_q  <= clamp_t;
      out_rbot_q  <= clamp_b;
      out_color_q <= s1_color_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= q_valid_i;
      if (s1_valid_q && emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign column_o      = out_col_q;
  assign row_top_o     = out_rtop_q;
  assign row_bottom_o  = out_rbot_q;
  assign pixel_color_o = out_color_q;

  `STSR_ASSERT_IMP(a_back_span_order, out_valid_q, out_rtop_q <= out_rbot_q, "span top below bottom")
  `STSR_ASSERT_IMP(a_back_no_clobber, out_valid_q && !out_ready_i, !(s1_valid_q && emit && s1_adv), "pending span overwritten")
  `STSR_ASSERT_IMP(a_back_pop_room, q_pop_o, s1_adv, "stage 1 loaded while held")

endmodule

`default_nettype wire
